// ===== rtl/rrc_pkg.sv =====
// ----------------------------------------------------------------------------
// rrc_pkg - shared definitions for the rational reconstruction core
// Field widths, reset values, register indexes and the microcode program.
// ----------------------------------------------------------------------------
`default_nettype none

package rrc_pkg;

	// Fixed field widths.
	localparam int unsigned NUM_W   = 62;
	localparam int unsigned DEN_W   = 31;
	localparam int unsigned CFG_W   = 62;
	localparam int unsigned CIDX_W  = 1;
	localparam int unsigned STEP_W  = 4;

	// Register reset values.
	localparam logic [CFG_W-1:0] MODULUS_RESET = 62'd998244353;
	localparam logic [DEN_W-1:0] LIMIT_RESET   = 31'd1000;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_MODULUS = 1'b0;
	localparam logic [CIDX_W-1:0] REG_LIMIT   = 1'b1;

	// Datapath actions.
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_UP,
		ACT_DOWN,
		ACT_NB,
		ACT_SETUP,
		ACT_ROTATE,
		ACT_EMIT
	} act_t;

	// Jump conditions.
	typedef enum logic [2:0] {
		CND_NEVER,
		CND_ALWAYS,
		CND_NOT_START,
		CND_DZERO,
		CND_CAN_UP,
		CND_K_NZ,
		CND_DONE
	} cnd_t;

	typedef struct packed {
		act_t              act;
		cnd_t              cnd;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// Program step addresses.
	localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_CHKD   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_NBUP   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_NBDN   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_NBST   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_TEST   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_UP     = 4'd6;
	localparam logic [STEP_W-1:0] STEP_DN     = 4'd7;
	localparam logic [STEP_W-1:0] STEP_ROT    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd9;

	// Microcode ROM: one control word per step.
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{act: ACT_NONE, cnd: CND_ALWAYS, target: STEP_WAIT};
		unique case (step)
			STEP_WAIT: w = '{act: ACT_LOAD,   cnd: CND_NOT_START, target: STEP_WAIT};
			STEP_CHKD: w = '{act: ACT_NONE,   cnd: CND_DZERO,     target: STEP_NBST};
			STEP_NBUP: w = '{act: ACT_UP,     cnd: CND_CAN_UP,    target: STEP_NBUP};
			STEP_NBDN: w = '{act: ACT_DOWN,   cnd: CND_K_NZ,      target: STEP_NBDN};
			STEP_NBST: w = '{act: ACT_NB,     cnd: CND_NEVER,     target: STEP_WAIT};
			STEP_TEST: w = '{act: ACT_SETUP,  cnd: CND_DONE,      target: STEP_EMIT};
			STEP_UP:   w = '{act: ACT_UP,     cnd: CND_CAN_UP,    target: STEP_UP};
			STEP_DN:   w = '{act: ACT_DOWN,   cnd: CND_K_NZ,      target: STEP_DN};
			STEP_ROT:  w = '{act: ACT_ROTATE, cnd: CND_ALWAYS,    target: STEP_TEST};
			STEP_EMIT: w = '{act: ACT_EMIT,   cnd: CND_ALWAYS,    target: STEP_WAIT};
			default:   w = '{act: ACT_NONE,   cnd: CND_ALWAYS,    target: STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rational_reconstruction_core.sv =====
// ----------------------------------------------------------------------------
// rational_reconstruction_core - fraction recovery from a modular residue
// Finds p/q with p = +/-x*q mod m, p below m/(2d) and q below d, by Euclid's
// remainder sequence on a shift-subtract datapath run by a microcode ROM.
// ----------------------------------------------------------------------------
// A residue item is taken when start is high and busy is low. The core then
// stays busy for a data-dependent run time and presents one result
// with done high for exactly one cycle; the receiver cannot stall it, so it
// must capture numerator, denominator and found in that cycle. Run time is
// set by the single shift-subtract divider that the microcode reuses for
// the numerator bound m/(2d) and for the quotient q of every Euclid step.
// The bound division and the Euclid quotients each add up to at most about
// DATA_WIDTH quotient bits. Long runs of unit quotients on a 62-bit modulus
// with a small limit are the slowest case.
// The modulus and denominator limit may only be written while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_reconstruction_core #(
	parameter int unsigned DATA_WIDTH = 62
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [rrc_pkg::NUM_W-1:0]             residue,
	input  wire logic                                  cfg_write,
	input  wire logic [rrc_pkg::CIDX_W-1:0]            cfg_index,
	input  wire logic [rrc_pkg::CFG_W-1:0]             cfg_data,
	output logic                                       done,
	output logic [rrc_pkg::NUM_W-1:0]                  numerator,
	output logic [rrc_pkg::DEN_W-1:0]                  denominator,
	output logic                                       found
);

	import rrc_pkg::*;

	// The divider must also hold 2*d, which is 32 bits wide.
	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam int unsigned KW = $clog2(XW);

	// Control state.
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [W-1:0]      modulus_q;
	logic [DEN_W-1:0]  limit_q;

	// Euclid pair (u = older row, v = current row) and numerator bound.
	logic [W-1:0]      ur_q, uc_q, vr_q, vc_q, nb_q;

	// Shift-subtract divider: remainder, shifted divisor, shifted cofactor,
	// cofactor accumulator and shift count.
	logic [XW-1:0]     r_q, dv_q, cm_q, acc_q;
	logic [KW-1:0]     k_q;

	logic [NUM_W-1:0]  numerator_q;
	logic [DEN_W-1:0]  denominator_q;
	logic              found_q;

	ctrl_t             ctrl;
	logic              cond_true;
	logic              can_up;
	logic              k_nz;
	logic              fits;
	logic              euclid_done;
	logic [XW-1:0]     dv_dbl;
	logic [XW-1:0]     vc_ext;

	assign ctrl   = ucode_rom(step_q);
	assign busy   = (step_q != STEP_WAIT);

	// The divisor may be doubled while it stays at or below the remainder.
	assign dv_dbl = {dv_q[XW-2:0], 1'b0};
	assign can_up = !dv_q[XW-1] && (dv_dbl <= r_q);
	assign k_nz   = (k_q != '0);

	// Both bounds hold for the current row.
	assign vc_ext      = XW'(vc_q);
	assign fits        = (vr_q < nb_q) && (vc_ext < XW'(limit_q));
	assign euclid_done = (vr_q == '0) || fits;

	always_comb begin
		unique case (ctrl.cnd)
			CND_NEVER:     cond_true = 1'b0;
			CND_ALWAYS:    cond_true = 1'b1;
			CND_NOT_START: cond_true = !start;
			CND_DZERO:     cond_true = (limit_q == '0);
			CND_CAN_UP:    cond_true = can_up;
			CND_K_NZ:      cond_true = k_nz;
			CND_DONE:      cond_true = euclid_done;
			default:       cond_true = 1'b0;
		endcase
	end

	// Step counter, result strobe and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_WAIT;
			done_q    <= 1'b0;
			modulus_q <= MODULUS_RESET[W-1:0];
			limit_q   <= LIMIT_RESET;
		end else begin
			step_q <= cond_true ? ctrl.target : STEP_W'(step_q + 1'b1);
			done_q <= (ctrl.act == ACT_EMIT);
			if (cfg_write) begin
				unique case (cfg_index)
					REG_MODULUS: modulus_q <= cfg_data[W-1:0];
					REG_LIMIT:   limit_q   <= cfg_data[DEN_W-1:0];
					default:     ;
				endcase
			end
		end
	end

	// Datapath, steered by the action field of the current control word.
	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			ACT_NONE: ;
			ACT_LOAD: begin
				// Start the bound division m / (2d) and the pairs (m,0), (x,1).
				ur_q  <= modulus_q;
				uc_q  <= '0;
				vr_q  <= residue[W-1:0];
				vc_q  <= W'(1);
				r_q   <= XW'(modulus_q);
				dv_q  <= XW'({limit_q, 1'b0});
				cm_q  <= XW'(1);
				acc_q <= '0;
				k_q   <= '0;
			end
			ACT_UP: begin
				if (can_up) begin
					dv_q <= dv_dbl;
					cm_q <= {cm_q[XW-2:0], 1'b0};
					k_q  <= KW'(k_q + 1'b1);
				end
			end
			ACT_DOWN: begin
				// One quotient bit: subtract the divisor, add the cofactor.
				if (dv_q <= r_q) begin
					r_q   <= r_q - dv_q;
					acc_q <= acc_q + cm_q;
				end
				if (k_nz) begin
					dv_q <= {1'b0, dv_q[XW-1:1]};
					cm_q <= {1'b0, cm_q[XW-1:1]};
					k_q  <= KW'(k_q - 1'b1);
				end
			end
			ACT_NB: nb_q <= acc_q[W-1:0];
			ACT_SETUP: begin
				// Divide ur by vr while accumulating uc + q*vc.
				r_q   <= XW'(ur_q);
				acc_q <= XW'(uc_q);
				dv_q  <= XW'(vr_q);
				cm_q  <= vc_ext;
				k_q   <= '0;
			end
			ACT_ROTATE: begin
				ur_q <= vr_q;
				uc_q <= vc_q;
				vr_q <= r_q[W-1:0];
				vc_q <= acc_q[W-1:0];
			end
			ACT_EMIT: begin
				found_q       <= fits;
				numerator_q   <= fits ? NUM_W'(vr_q) : '0;
				denominator_q <= fits ? vc_ext[DEN_W-1:0] : '0;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign numerator   = numerator_q;
	assign denominator = denominator_q;
	assign found       = found_q;

`ifndef SYNTH
	// An accepted item always makes the core busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start the sequencer");

	// A result only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// A result strobe is always followed by done low.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// A failed search reports zero values.
	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (numerator == '0 && denominator == '0))
		else $error("nonzero values reported without a fraction");
`endif

endmodule

`default_nettype wire
